// ----- rtl/core/chorus_pkg.sv -----
// Shared constants, register indexes and the LFO sine table of the chorus block.
`default_nettype none

package chorus_pkg;

    // Delay store geometry.
    localparam int DELAY_DEPTH = 2048;
    localparam int DELAY_AW    = 11;

    // Sine table geometry; entries are Q1.16 values from 0 to 65536.
    localparam int SINE_DEPTH = 1024;
    localparam int SINE_AW    = 10;
    localparam int LFO_W      = 17;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ENABLE   = 3'd0;
    localparam logic [2:0] CFG_STEP     = 3'd1;
    localparam logic [2:0] CFG_FEEDBACK = 3'd2;
    localparam logic [2:0] CFG_MIX      = 3'd3;
    localparam logic [2:0] CFG_MAXDLY   = 3'd4;

    typedef logic [LFO_W-1:0] t_sine_rom [SINE_DEPTH];

    // Polynomial quarter wave in Q16, input 0..65536.
    function automatic logic [16:0] quarter_sine(input logic [16:0] t);
        logic [63:0] tt;
        logic [63:0] u;
        logic [63:0] v;
        logic [63:0] w;
        logic [63:0] f;
        tt = {47'd0, t};
        u  = (tt * tt) >> 16;
        v  = 64'd42334 - ((64'd4926 * u) >> 16);
        w  = 64'd102944 - ((u * v) >> 16);
        f  = (tt * w) >> 16;
        return f[16:0];
    endfunction

    // Table entry k holds (1 + sin(2*pi*k/SINE_DEPTH)) / 2 in Q1.16.
    function automatic logic [LFO_W-1:0] sine_entry(input int unsigned k);
        logic [63:0] p;
        logic [1:0]  q;
        logic [16:0] t;
        logic [16:0] f;
        logic [17:0] e;
        p = ({32'd0, k} << 18) >> SINE_AW;
        q = p[17:16];
        t = {1'b0, p[15:0]};
        f = q[0] ? quarter_sine(17'd65536 - t) : quarter_sine(t);
        e = q[1] ? (18'd65536 - {1'b0, f}) : (18'd65536 + {1'b0, f});
        return e[17:1];
    endfunction

    function automatic t_sine_rom build_sine();
        t_sine_rom rom;
        for (int k = 0; k < SINE_DEPTH; k++) begin
            rom[k] = sine_entry(k);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine();

endpackage

`default_nettype wire

// ----- rtl/core/chorus_modulated_delay.sv -----
// Chorus top level: modulated delay line with feedback and wet/dry mix.
// With the effect enabled the sequencer walks the LFO lookup, the two-port delay
// store read and six products, one per step, and registers the result at the
// output step; a bypassed item goes straight from idle to the output step. A new
// input is taken only once the last item has left through a free output register.
// Reset is synchronous and active low; the delay store reads as zero until written.
`default_nettype none

module chorus_modulated_delay
    import chorus_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Configuration write port.
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [30:0]        i_cfg_data,
    // Input channel.
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic signed [15:0] i_sample_in,
    // Output channel.
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [15:0]      o_sample_out
);

    // The sequencer steps through one sample at a time. Each step ends in a
    // register, and no step holds more than one multiplication.
    typedef enum logic [3:0] {
        S_IDLE,
        S_LFO,
        S_DLY,
        S_RD,
        S_M1,
        S_M2,
        S_FB,
        S_MX,
        S_OUT
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic        r_enable;
    logic [30:0] r_phase_step;
    logic [14:0] r_feedback;
    logic [15:0] r_mix;
    logic [10:0] r_max_delay;

    // Control state.
    logic                r_out_valid;
    logic                r_byp;
    logic [DELAY_AW-1:0] r_wp;
    logic                r_filled;

    // Datapath registers.
    logic signed [15:0] r_x;
    logic [27:0]        r_delay;
    logic [15:0]        r_frac;
    logic               r_v1;
    logic               r_v2;
    logic signed [17:0] r_rd1;
    logic signed [17:0] r_rd2;
    logic signed [35:0] r_prod;
    logic signed [17:0] r_dly;
    logic signed [17:0] r_wet;
    logic signed [15:0] r_out_data;

    // The delay store. Entries that were never written since reset are masked
    // to zero: writes run in order from entry zero, so an entry below the write
    // pointer, or any entry once the pointer has wrapped, holds real data.
    logic signed [17:0] r_mem [DELAY_DEPTH];

    logic [LFO_W-1:0]    w_lfo;
    logic [DELAY_AW-1:0] w_di;
    logic [DELAY_AW-1:0] w_i1;
    logic [DELAY_AW-1:0] w_i2;
    logic                w_commit;
    logic                w_update;
    logic [15:0]         w_mix_eff;
    logic [15:0]         w_dry;
    logic signed [17:0]  w_d1;
    logic signed [17:0]  w_d2;
    logic signed [35:0]  w_sum;
    logic signed [35:0]  w_sum_r;
    logic signed [33:0]  w_fbp;
    logic signed [33:0]  w_fbr;
    logic signed [18:0]  w_fb_sh;
    logic signed [19:0]  w_wet_full;
    logic signed [17:0]  w_wet_sat;
    logic signed [32:0]  w_dryp;
    logic signed [35:0]  w_ysum;
    logic signed [20:0]  w_ysh;
    logic signed [15:0]  w_y_sat;

    // The integer part of the delay counts back from the write pointer; the
    // neighbor one entry older is the second interpolation tap. A zero delay
    // reads the entry about to be overwritten, which is the oldest one.
    assign w_di = r_delay[16 +: DELAY_AW];
    assign w_i1 = r_wp - w_di;
    assign w_i2 = w_i1 - 1'b1;

    // An item leaves when the output register is free or being emptied.
    assign w_commit = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    assign w_update = w_commit && !r_byp;

    // Mix gains above one saturate to one.
    assign w_mix_eff = (r_mix > 16'd32768) ? 16'd32768 : r_mix;
    assign w_dry     = 16'd32768 - w_mix_eff;

    // Linear interpolation between the two taps, rounded to nearest with halves up.
    assign w_d1    = r_v1 ? r_rd1 : 18'sd0;
    assign w_d2    = r_v2 ? r_rd2 : 18'sd0;
    assign w_sum   = r_prod + 36'($signed({1'b0, r_frac}) * w_d2);
    assign w_sum_r = w_sum + 36'sd32768;

    // Feedback into the line; the stored value saturates to 18 bits.
    assign w_fbp      = $signed({1'b0, r_feedback}) * r_dly;
    assign w_fbr      = w_fbp + 34'sd16384;
    assign w_fb_sh    = w_fbr[33:15];
    assign w_wet_full = 20'(r_x) + 20'(w_fb_sh);

    always_comb begin
        if (w_wet_full > 20'sd131071) begin
            w_wet_sat = 18'sd131071;
        end else if (w_wet_full < -20'sd131072) begin
            w_wet_sat = -18'sd131072;
        end else begin
            w_wet_sat = w_wet_full[17:0];
        end
    end

    // Output mix: the wet product is already in r_prod, the dry one is added here.
    assign w_dryp = $signed({1'b0, w_dry}) * r_x;
    assign w_ysum = r_prod + 36'(w_dryp) + 36'sd16384;
    assign w_ysh  = w_ysum[35:15];

    always_comb begin
        if (w_ysh > 21'sd32767) begin
            w_y_sat = 16'sh7fff;
        end else if (w_ysh < -21'sd32768) begin
            w_y_sat = -16'sd32768;
        end else begin
            w_y_sat = w_ysh[15:0];
        end
    end

    chorus_lfo u_lfo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_lookup     (r_state == S_LFO),
        .i_advance    (w_update),
        .i_phase_step (r_phase_step),
        .o_lfo        (w_lfo)
    );

    // Delay store: two reads and one write per cycle, read data registered.
    always_ff @(posedge i_clk) begin
        if (w_update) begin
            r_mem[r_wp] <= r_wet;
        end
        r_rd1 <= r_mem[w_i1];
        r_rd2 <= r_mem[w_i2];
    end

    // Sequencer, configuration and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_enable     <= 1'b0;
            r_phase_step <= 31'd44739;
            r_feedback   <= 15'd9830;
            r_mix        <= 16'd16384;
            r_max_delay  <= 11'd1200;
            r_out_valid  <= 1'b0;
            r_byp        <= 1'b0;
            r_wp         <= '0;
            r_filled     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ENABLE:   r_enable     <= i_cfg_data[0];
                    CFG_STEP:     r_phase_step <= i_cfg_data;
                    CFG_FEEDBACK: r_feedback   <= i_cfg_data[14:0];
                    CFG_MIX:      r_mix        <= i_cfg_data[15:0];
                    CFG_MAXDLY:   r_max_delay  <= i_cfg_data[10:0];
                    default: ;
                endcase
            end

            // A result loaded in the same cycle keeps the output valid.
            if (r_out_valid && i_out_ready && !w_commit) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_x     <= i_sample_in;
                        r_byp   <= !r_enable;
                        r_state <= r_enable ? S_LFO : S_OUT;
                    end
                end
                S_LFO: begin
                    r_state <= S_DLY;
                end
                S_DLY: begin
                    r_delay <= 28'(w_lfo) * 28'(r_max_delay);
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_frac  <= r_delay[15:0];
                    r_v1    <= r_filled || (w_i1 < r_wp);
                    r_v2    <= r_filled || (w_i2 < r_wp);
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_prod  <= 36'($signed({1'b0, 17'd65536 - {1'b0, r_frac}}) * w_d1);
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_dly   <= w_sum_r[33:16];
                    r_state <= S_FB;
                end
                S_FB: begin
                    r_wet   <= w_wet_sat;
                    r_state <= S_MX;
                end
                S_MX: begin
                    r_prod  <= 36'($signed({1'b0, w_mix_eff}) * r_wet);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_commit) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_byp ? r_x : w_y_sat;
                        r_state     <= S_IDLE;
                        if (!r_byp) begin
                            r_wp <= r_wp + 1'b1;
                            if (r_wp == DELAY_AW'(DELAY_DEPTH - 1)) begin
                                r_filled <= 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_data;

    // A processed sample advances the write pointer by exactly one entry.
    a_wp_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_update |=> (r_wp == $past(r_wp) + 1'b1))
        else $error("write pointer did not advance after a processed sample");

    // The write pointer moves only when a processed sample leaves.
    a_wp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_update |=> $stable(r_wp))
        else $error("write pointer moved without a processed sample");

    // Once the store has wrapped, every entry holds written data for good.
    a_filled_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled |=> r_filled)
        else $error("store filled flag dropped outside reset");

    // A result is only loaded into a free or draining output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_out_data))
        else $error("pending output overwritten");

endmodule

`default_nettype wire

// ----- rtl/core/chorus_lfo.sv -----
// LFO of the chorus: phase accumulator and registered sine table lookup.
`default_nettype none

module chorus_lfo
    import chorus_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_lookup,
    input  wire logic             i_advance,
    input  wire logic [30:0]      i_phase_step,
    output logic      [LFO_W-1:0] o_lfo
);

    logic [31:0]      r_phase;
    logic [LFO_W-1:0] r_lfo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_advance) begin
            r_phase <= r_phase + {1'b0, i_phase_step};
        end
    end

    // The table index is the top bits of the phase.
    always_ff @(posedge i_clk) begin
        if (i_lookup) begin
            r_lfo <= SINE_ROM[r_phase[31 -: SINE_AW]];
        end
    end

    assign o_lfo = r_lfo;

endmodule

`default_nettype wire
